/* hdl/rau_pkg.sv */
// Package for the rational arithmetic unit.
// Holds widths, command codes and the control, status and result types.
// No dependencies.
`default_nettype none
package rau_pkg;

  localparam int OW = 16;
  localparam int FIELD_W = 16;
  localparam int PW = 2 * OW;
  localparam int SW = 2 * OW + 1;
  localparam int KW = $clog2(SW + 1);
  localparam int CNT_W = $clog2(SW + 1);
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;
  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 72;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;

  localparam logic [1:0] MUL_P = 2'd0;
  localparam logic [1:0] MUL_Q = 2'd1;
  localparam logic [1:0] MUL_D = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       sum_en;
    logic       gcd_step;
    logic       div_step;
    logic       div_next;
    logic       div_store_den;
  } rau_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic early;
  } rau_stat_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic                        is_equal;
    logic                        is_less;
    logic                        error;
  } rau_res_t;

endpackage
`default_nettype wire

/* hdl/rau_ctrl.sv */
// Controller state machine of the rational arithmetic unit.
// Sequences multiply, sum, GCD and division steps; uses rau_pkg.
`default_nettype none
module rau_ctrl import rau_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      out_free_i,
  input  wire rau_stat_t stat_i,
  output rau_cmd_t       cmd_o,
  output logic           in_ready_o,
  output logic           fin_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_GCD  = 4'd3;
  localparam logic [3:0] S_DIVN = 4'd4;
  localparam logic [3:0] S_DIVX = 4'd5;
  localparam logic [3:0] S_DIVD = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    fin_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = cnt_q[1:0];
        if (cnt_q[1:0] == MUL_D) begin
          state_d = stat_i.early ? S_DONE : S_SUM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d = S_GCD;
      end
      S_GCD: begin
        cmd_o.gcd_step = 1'b1;
        if (stat_i.gcd_done) begin
          cnt_d = '0;
          state_d = S_DIVN;
        end
      end
      S_DIVN: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(SW - 1)) begin
          state_d = S_DIVX;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DIVX: begin
        cmd_o.div_next = 1'b1;
        cnt_d = '0;
        state_d = S_DIVD;
      end
      S_DIVD: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(SW - 1)) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.div_store_den = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          fin_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/rau_dp.sv */
// Datapath of the rational arithmetic unit: operand decode, shared
// multiplier, signed sum, binary GCD and a bit-serial divider; uses rau_pkg.
`default_nettype none
module rau_dp import rau_pkg::*; (
  input  wire logic               clk_i,
  input  wire rau_cmd_t           cmd_i,
  input  wire logic [2:0]         cmd_code_i,
  input  wire logic [FIELD_W-1:0] a_num_i,
  input  wire logic [FIELD_W-1:0] a_den_i,
  input  wire logic [FIELD_W-1:0] b_num_i,
  input  wire logic [FIELD_W-1:0] b_den_i,
  output rau_stat_t               stat_o,
  output rau_res_t                res_o
);

  function automatic logic [OW:0] to_smag(logic [FIELD_W-1:0] raw);
    logic [OW+FIELD_W-1:0] ext;
    logic [OW-1:0]         v;
    ext = {{OW{raw[FIELD_W-1]}}, raw};
    v = ext[OW-1:0];
    to_smag = v[OW-1] ? {1'b1, OW'(-v)} : {1'b0, v};
  endfunction

  logic [OW:0] an_s, ad_s, bn_s, bd_s;
  logic [OW-1:0] an_q, ad_q, bn_q, bd_q;
  logic sa_q, sb_q, err_q, cmp_q, rneg_q;
  logic [2:0] op_q;
  logic [PW-1:0] pr0_q, pr1_q, pr2_q;
  logic [SW-1:0] num_q, den_q, u_q, v_q, g_q, dq_q, rem_q;
  logic [KW-1:0] k_q;

  logic [OW-1:0] ma, mb;
  logic [PW-1:0] prod;
  logic [SW-1:0] p_x, q_x, sum_mag, gshift;
  logic sq, sum_neg;
  logic [SW:0] sh, diff;
  logic ge;
  logic signed [SW-1:0] nsv;
  logic eq, lt;

  assign an_s = to_smag(a_num_i);
  assign ad_s = to_smag(a_den_i);
  assign bn_s = to_smag(b_num_i);
  assign bd_s = to_smag(b_den_i);

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_P: begin
        ma = an_q;
        mb = (op_q == CMD_MUL) ? bn_q : bd_q;
      end
      MUL_Q: begin
        ma = bn_q;
        mb = ad_q;
      end
      default: begin
        ma = ad_q;
        mb = (op_q == CMD_DIV) ? bn_q : bd_q;
      end
    endcase
  end
  assign prod = PW'(ma) * PW'(mb);

  assign p_x = SW'(pr0_q);
  assign q_x = SW'(pr1_q);
  assign sq = (op_q == CMD_SUB) ? ((pr1_q != '0) && !sb_q) : sb_q;
  always_comb begin
    if (sa_q == sq) begin
      sum_mag = p_x + q_x;
      sum_neg = sa_q;
    end else if (p_x >= q_x) begin
      sum_mag = p_x - q_x;
      sum_neg = sa_q;
    end else begin
      sum_mag = q_x - p_x;
      sum_neg = sq;
    end
  end

  assign gshift = u_q << k_q;
  assign stat_o.gcd_done = (u_q == '0) || (v_q == '0);
  assign stat_o.early = err_q || cmp_q;

  assign sh = {rem_q, dq_q[SW-1]};
  assign diff = sh - {1'b0, g_q};
  assign ge = sh >= {1'b0, g_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      an_q <= an_s[OW-1:0];
      ad_q <= ad_s[OW-1:0];
      bn_q <= bn_s[OW-1:0];
      bd_q <= bd_s[OW-1:0];
      sa_q <= (an_s[OW-1:0] != '0) && (an_s[OW] != ad_s[OW]);
      sb_q <= (bn_s[OW-1:0] != '0) && (bn_s[OW] != bd_s[OW]);
      op_q <= cmd_code_i;
      cmp_q <= cmd_code_i == CMD_CMP;
      err_q <= (ad_s[OW-1:0] == '0) || (bd_s[OW-1:0] == '0) || (cmd_code_i > CMD_CMP) ||
               ((cmd_code_i == CMD_DIV) && (bn_s[OW-1:0] == '0));
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        MUL_P: pr0_q <= prod;
        MUL_Q: pr1_q <= prod;
        default: pr2_q <= prod;
      endcase
    end
    if (cmd_i.sum_en) begin
      if ((op_q == CMD_ADD) || (op_q == CMD_SUB)) begin
        num_q <= sum_mag;
        u_q <= sum_mag;
        rneg_q <= sum_neg && (sum_mag != '0);
      end else begin
        num_q <= p_x;
        u_q <= p_x;
        rneg_q <= (pr0_q != '0) && (sa_q != sb_q);
      end
      den_q <= SW'(pr2_q);
      v_q <= SW'(pr2_q);
      k_q <= '0;
    end
    if (cmd_i.gcd_step) begin
      if (v_q == '0) begin
        g_q <= gshift;
        dq_q <= num_q;
        rem_q <= '0;
      end else if (u_q == '0) begin
        g_q <= v_q;
        dq_q <= num_q;
        rem_q <= '0;
      end else if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q > v_q) begin
        u_q <= v_q;
        v_q <= u_q - v_q;
      end else begin
        v_q <= v_q - u_q;
      end
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[SW-1:0] : sh[SW-1:0];
      dq_q <= {dq_q[SW-2:0], ge};
    end
    if (cmd_i.div_next) begin
      num_q <= dq_q;
      dq_q <= den_q;
      rem_q <= '0;
    end
    if (cmd_i.div_store_den) begin
      den_q <= dq_q;
    end
  end

  always_comb begin
    if (sa_q != sb_q) begin
      eq = 1'b0;
      lt = sa_q;
    end else begin
      eq = pr0_q == pr1_q;
      lt = sa_q ? (pr0_q > pr1_q) : (pr0_q < pr1_q);
    end
  end

  assign nsv = rneg_q ? -$signed(num_q) : $signed(num_q);

  always_comb begin
    res_o.res_num = '0;
    res_o.res_den = RES_DEN_W'(1);
    res_o.is_equal = 1'b0;
    res_o.is_less = 1'b0;
    res_o.error = 1'b0;
    if (err_q) begin
      res_o.error = 1'b1;
    end else if (cmp_q) begin
      res_o.is_equal = eq;
      res_o.is_less = lt;
    end else begin
      res_o.res_num = RES_NUM_W'(nsv);
      res_o.res_den = RES_DEN_W'(den_q);
    end
  end

endmodule
`default_nettype wire

/* hdl/rational_arithmetic_unit_core.sv */
// Rational arithmetic unit: add, subtract, multiply, divide or compare two
// fractions, with the result reduced to lowest terms. One request is worked
// at a time. Compare, error and unknown commands raise the result valid after
// the three multiplier products. Arithmetic then forms the result fraction
// (a signed sum for add and subtract), runs binary GCD steps on the 33-bit
// magnitudes of the 16-bit operands, and uses the bit-serial divider to
// divide numerator and denominator by the GCD.
// The result register lets a new request be accepted while the previous
// result waits.
// Uses rau_pkg, rau_ctrl and rau_dp.
`default_nettype none
module rational_arithmetic_unit_core import rau_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // cmd[2:0], a_num[18:3], a_den[34:19], b_num[50:35], b_den[66:51], zeros
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // res_num[32:0], res_den[63:33], is_equal[64], is_less[65], error[66], zeros
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o
);

  rau_cmd_t  cmd;
  rau_stat_t stat;
  rau_res_t  res, out_q;
  logic      m_valid_q, out_free, fin;

  assign out_free = !m_valid_q || m_axis_tready_i;

  rau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready_o),
    .fin_o      (fin)
  );

  rau_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .cmd_code_i (s_axis_tdata_i[2:0]),
    .a_num_i    (s_axis_tdata_i[18:3]),
    .a_den_i    (s_axis_tdata_i[34:19]),
    .b_num_i    (s_axis_tdata_i[50:35]),
    .b_den_i    (s_axis_tdata_i[66:51]),
    .stat_o     (stat),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fin) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o = {5'd0, out_q.error, out_q.is_less, out_q.is_equal,
                           out_q.res_den, out_q.res_num};

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && out_q.error |-> (out_q.res_num == '0) && (out_q.res_den == RES_DEN_W'(1)))
    else $error("error result carries a nonzero fraction");

  a_zero_den_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (out_q.res_num == '0) |-> out_q.res_den == RES_DEN_W'(1))
    else $error("zero numerator without unit denominator");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> out_q.res_den != '0)
    else $error("zero denominator in result");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> !s_axis_tready_o || !$past(s_axis_tready_o))
    else $error("request accepted while a result was being finished");

endmodule
`default_nettype wire
